// ----- design/datetime_timezone_shift_assert.svh -----
// Assertion macros shared by the checker of the zone shift block.
`ifndef DATETIME_TIMEZONE_SHIFT_ASSERT_SVH
`define DATETIME_TIMEZONE_SHIFT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTS_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("zone shift check failed");

// The consequent must hold in the cycle after the antecedent.
`define DTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("zone shift check failed");

`endif

// ----- design/dts_pkg.sv -----
// Types, constants and small calendar functions for the zone shift pipeline.
package dts_pkg;

	// Input selector codes.
	localparam logic [1:0] FUNC_NONE     = 2'd0;
	localparam logic [1:0] FUNC_DATE     = 2'd1;
	localparam logic [1:0] FUNC_DATETIME = 2'd2;

	// Time-of-day constants.
	localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [11:0] SECS_PER_MIN  = 12'd60;
	localparam logic [18:0] SECS_PER_DAY  = 19'd86400;
	localparam logic [18:0] LAST_SEC      = 19'd86399;

	// Calendar constants.
	localparam logic [13:0] YEAR_FLOOR = 14'd1901;
	localparam logic [14:0] YEAR_BIAS  = 15'd400;
	localparam logic [3:0]  MONTH_JAN  = 4'd1;
	localparam logic [3:0]  MONTH_MAR  = 4'd3;
	localparam logic [3:0]  MONTH_DEC  = 4'd12;
	localparam logic [4:0]  DEC_DAYS   = 5'd31;
	localparam logic [14:0] TWENTY_FIVE = 15'd25;

	// Reciprocals for division by constants, exact over the ranges used here.
	// x / 25 = (x * 20972) >> 19 for x < 16384.
	localparam logic [14:0] RECIP_25   = 15'd20972;
	// x / 3600 = (x * 37283) >> 27 for x < 86400.
	localparam logic [15:0] RECIP_3600 = 16'd37283;
	// x / 60 = (x * 2185) >> 17 for x < 3600.
	localparam logic [11:0] RECIP_60   = 12'd2185;

	// Flags that travel with each beat.
	typedef struct packed {
		logic has_date;
		logic has_time;
		logic shift;
	} ctrl_t;

	typedef struct packed {
		logic [13:0] y;
		logic [3:0]  m;
		logic [4:0]  d;
	} date_t;

	typedef struct packed {
		logic [4:0] h;
		logic [5:0] mi;
		logic [5:0] s;
	} hms_t;

	// Month length; months outside 1 to 12 count as 31 days.
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m) inside
			4'd2:                      n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
			default:                   n = 5'd31;
		endcase
		return n;
	endfunction

	// Month term of the weekday sum: (13 * mm + 8) / 5, where January and
	// February (and month zero) count as months 13, 14 and 12 of the year before.
	function automatic logic [5:0] month_term(input logic [3:0] m);
		logic [5:0] r;
		case (m)
			4'd0:    r = 6'd32;
			4'd1:    r = 6'd35;
			4'd2:    r = 6'd38;
			4'd3:    r = 6'd9;
			4'd4:    r = 6'd12;
			4'd5:    r = 6'd14;
			4'd6:    r = 6'd17;
			4'd7:    r = 6'd19;
			4'd8:    r = 6'd22;
			4'd9:    r = 6'd25;
			4'd10:   r = 6'd27;
			4'd11:   r = 6'd30;
			4'd12:   r = 6'd32;
			4'd13:   r = 6'd35;
			4'd14:   r = 6'd38;
			default: r = 6'd40;
		endcase
		return r;
	endfunction

	// Remainder by seven, folding octal digits since 8 is 1 modulo 7.
	function automatic logic [2:0] mod7(input logic [15:0] v);
		logic [5:0] a;
		logic [3:0] b;
		a = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]) + 6'(v[15]);
		b = 4'(a[2:0]) + 4'(a[5:3]);
		return (b >= 4'd7) ? 3'(b - 4'd7) : b[2:0];
	endfunction

endpackage

// ----- design/datetime_timezone_shift.sv -----
// Zone shift of a decoded date and time of day, with weekday, as a six stage pipeline.
//
// One beat enters per clock while in_stall is low, and each result leaves from
// the stage 6 register. Stage 1 forms the seconds of day and the year's
// quotient by 25; stage 2 adds the zone offset, decides whether the date moves
// back or forward one day and finds the leap year; stage 3 rolls day, month and
// year and divides the seconds by 3600; stage 4 forms the remainder within the
// hour and starts the weekday (year quotient by 100); stage 5 divides by 60 and
// adds up the weekday sum; stage 6 finishes seconds and the weekday modulo 7
// and is the output register. Each stage holds while the stage after it is full
// and stalled, so in_stall rises only when all six stages are full and
// out_stall is high. The offset register must only be written while the
// pipeline is empty.
module datetime_timezone_shift (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic signed [16:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [13:0]        year,
	input  logic [3:0]         month,
	input  logic [4:0]         day,
	input  logic [4:0]         hour,
	input  logic [5:0]         minute,
	input  logic [5:0]         second,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [13:0]        out_year,
	output logic [3:0]         out_month,
	output logic [4:0]         out_day,
	output logic [4:0]         out_hour,
	output logic [5:0]         out_minute,
	output logic [5:0]         out_second,
	output logic [2:0]         weekday
);
	import dts_pkg::*;

	logic signed [16:0] offset_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	ctrl_t ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5;
	date_t date_s1, date_s2, date_s3, date_s4, date_s5, date_s6;
	hms_t  raw_s1, raw_s2, raw_s3, raw_s4, raw_s5, hms_s6;

	logic [16:0] tod_s1;
	logic [9:0]  q25_s1;
	logic [16:0] t_s2, t_s3;
	logic        back_s2, fwd_s2;
	logic [4:0]  dim_cur_s2, dim_prev_s2;
	logic [4:0]  hq_s3, hq_s4, hq_s5;
	logic [11:0] rem_s4, rem_s5;
	logic [14:0] yy_s4;
	logic [8:0]  q100_s4;
	logic [5:0]  mterm_s4;
	logic [5:0]  mi_s5;
	logic [15:0] sum_s5;
	logic [2:0]  wd_s6;

	// Offset register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	// A stage loads when it is empty or its contents move on.
	assign en_s6    = !v_s6 || !out_stall;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: seconds of day and year divided by 25.
	ctrl_t       ctrl_c1;
	logic [16:0] tod_c1;
	logic [28:0] yprod_c1;

	always_comb begin
		ctrl_c1.has_date = (func != FUNC_NONE);
		ctrl_c1.has_time = (func >= FUNC_DATETIME);
		ctrl_c1.shift    = ctrl_c1.has_time && (offset_q != 17'sd0);
		tod_c1   = 17'(hour) * SECS_PER_HOUR + 17'(minute) * 17'(SECS_PER_MIN) + 17'(second);
		yprod_c1 = 29'(year) * 29'(RECIP_25);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ctrl_s1 <= ctrl_c1;
			date_s1 <= '{y: year, m: month, d: day};
			raw_s1  <= '{h: hour, mi: minute, s: second};
			tod_s1  <= tod_c1;
			q25_s1  <= yprod_c1[28:19];
		end
	end

	// Stage 2: add the offset, pick the day move, find leap year and month lengths.
	logic signed [18:0] t_c2;
	logic [18:0]        tu_c2, tadj_c2, tclamp_c2;
	logic               neg_c2, over_c2;
	logic [14:0]        x25_c2;
	logic               leap_c2;

	always_comb begin
		t_c2   = $signed({2'b00, tod_s1}) + $signed({{2{offset_q[16]}}, offset_q});
		tu_c2  = t_c2;
		neg_c2 = tu_c2[18];
		over_c2 = !neg_c2 && (tu_c2 >= SECS_PER_DAY);
		if (neg_c2) begin
			tadj_c2 = tu_c2 + SECS_PER_DAY;
		end else if (over_c2) begin
			tadj_c2 = tu_c2 - SECS_PER_DAY;
		end else begin
			tadj_c2 = tu_c2;
		end
		tclamp_c2 = (tadj_c2 > LAST_SEC) ? LAST_SEC : tadj_c2;
		// Leap: divisible by 4 and either not by 25 or also by 16.
		x25_c2  = 15'(q25_s1) * TWENTY_FIVE;
		leap_c2 = (date_s1.y[1:0] == 2'b00) &&
			((x25_c2 != {1'b0, date_s1.y}) || (date_s1.y[3:0] == 4'b0000));
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ctrl_s2     <= ctrl_s1;
			date_s2     <= date_s1;
			raw_s2      <= raw_s1;
			t_s2        <= tclamp_c2[16:0];
			back_s2     <= ctrl_s1.shift && neg_c2;
			fwd_s2      <= ctrl_s1.shift && over_c2;
			dim_cur_s2  <= month_days(date_s1.m, leap_c2);
			dim_prev_s2 <= month_days(date_s1.m - 4'd1, leap_c2);
		end
	end

	// Stage 3: roll the date by one day and divide the seconds by 3600.
	date_t       date_c3;
	logic [32:0] hprod_c3;

	always_comb begin
		date_c3 = date_s2;
		if (back_s2) begin
			if (date_s2.d <= 5'd1) begin
				if (date_s2.m <= MONTH_JAN) begin
					if (date_s2.y > YEAR_FLOOR) begin
						date_c3.y = date_s2.y - 14'd1;
					end
					date_c3.m = MONTH_DEC;
					date_c3.d = DEC_DAYS;
				end else begin
					date_c3.m = date_s2.m - 4'd1;
					date_c3.d = dim_prev_s2;
				end
			end else begin
				date_c3.d = date_s2.d - 5'd1;
			end
		end else if (fwd_s2) begin
			if (date_s2.d >= dim_cur_s2) begin
				if (date_s2.m >= MONTH_DEC) begin
					date_c3.y = date_s2.y + 14'd1;
					date_c3.m = MONTH_JAN;
				end else begin
					date_c3.m = date_s2.m + 4'd1;
				end
				date_c3.d = 5'd1;
			end else begin
				date_c3.d = date_s2.d + 5'd1;
			end
		end
		hprod_c3 = 33'(t_s2) * 33'(RECIP_3600);
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			ctrl_s3 <= ctrl_s2;
			date_s3 <= date_c3;
			raw_s3  <= raw_s2;
			t_s3    <= t_s2;
			hq_s3   <= hprod_c3[31:27];
		end
	end

	// Stage 4: seconds within the hour; weekday year terms.
	logic [16:0] rem_c4;
	logic [14:0] yy_c4;
	logic [27:0] qprod_c4;

	always_comb begin
		rem_c4   = t_s3 - 17'(hq_s3) * SECS_PER_HOUR;
		yy_c4    = {1'b0, date_s3.y} + YEAR_BIAS - ((date_s3.m < MONTH_MAR) ? 15'd1 : 15'd0);
		qprod_c4 = 28'(yy_c4[14:2]) * 28'(RECIP_25);
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			ctrl_s4  <= ctrl_s3;
			date_s4  <= date_s3;
			raw_s4   <= raw_s3;
			hq_s4    <= hq_s3;
			rem_s4   <= rem_c4[11:0];
			yy_s4    <= yy_c4;
			q100_s4  <= qprod_c4[27:19];
			mterm_s4 <= month_term(date_s3.m);
		end
	end

	// Stage 5: minutes, and the weekday sum.
	logic [23:0] mprod_c5;
	logic [15:0] sum_c5;

	always_comb begin
		mprod_c5 = 24'(rem_s4) * 24'(RECIP_60);
		sum_c5   = 16'(yy_s4) + 16'(yy_s4[14:2]) - 16'(q100_s4) + 16'(q100_s4[8:2]) +
			16'(mterm_s4) + 16'(date_s4.d);
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			ctrl_s5 <= ctrl_s4;
			date_s5 <= date_s4;
			raw_s5  <= raw_s4;
			hq_s5   <= hq_s4;
			rem_s5  <= rem_s4;
			mi_s5   <= mprod_c5[22:17];
			sum_s5  <= sum_c5;
		end
	end

	// Stage 6: seconds, weekday, and the selection of the result fields.
	logic [11:0] sec_c6;
	hms_t        hms_c6;

	always_comb begin
		sec_c6 = rem_s5 - 12'(mi_s5) * SECS_PER_MIN;
		if (!ctrl_s5.has_date || !ctrl_s5.has_time) begin
			hms_c6 = '0;
		end else if (ctrl_s5.shift) begin
			hms_c6 = '{h: hq_s5, mi: mi_s5, s: sec_c6[5:0]};
		end else begin
			hms_c6 = raw_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			date_s6 <= ctrl_s5.has_date ? date_s5 : '0;
			hms_s6  <= hms_c6;
			wd_s6   <= ctrl_s5.has_date ? mod7(sum_s5) : 3'd0;
		end
	end

	assign out_valid  = v_s6;
	assign out_year   = date_s6.y;
	assign out_month  = date_s6.m;
	assign out_day    = date_s6.d;
	assign out_hour   = hms_s6.h;
	assign out_minute = hms_s6.mi;
	assign out_second = hms_s6.s;
	assign weekday    = wd_s6;

endmodule

// ----- design/dts_checker.sv -----
// Port-level checks for the zone shift pipeline and their binding to it.
`include "datetime_timezone_shift_assert.svh"

module dts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [13:0] out_year,
	input logic [3:0]  out_month,
	input logic [4:0]  out_day,
	input logic [4:0]  out_hour,
	input logic [5:0]  out_minute,
	input logic [5:0]  out_second,
	input logic [2:0]  weekday
);

	// All result fields of the beat on the output, gathered for the hold check.
	logic [42:0] out_bits;

	assign out_bits = {out_year, out_month, out_day, out_hour, out_minute, out_second, weekday};

	// A stalled result beat stays and keeps its fields.
	`DTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_bits))

	// With the output free, every stage moves, so the input never stalls.
	`DTS_ASSERT_IMPLY(a_no_back_pressure, !out_stall, !in_stall)

	// The weekday is always a remainder by seven.
	`DTS_ASSERT_IMPLY(a_weekday_range, out_valid, weekday <= 3'd6)

endmodule

bind datetime_timezone_shift dts_checker u_dts_checker (.*);

// ----- sim/testbench.sv -----
// Self-checking testbench for the zone shift block: directed calendar cases, then random beats.
`timescale 1ns / 1ps

module testbench;
	import dts_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 10;
	localparam int PIPE_DEPTH = 6;
	localparam int HOUR_SECS = 3600;
	localparam int DAY_SECS = 24 * 3600;
	localparam int EARLY_YEAR = 1901;
	localparam int WEEK_YEAR_BIAS = 400;
	localparam int ZONE_MAX = 65535;
	localparam int ZONE_MIN = -65536;
	localparam int ZONE_SPAN = 50400;
	localparam logic [1:0] FUNC_ALIAS = 2'd3;

	// One input beat.
	typedef struct {
		logic [1:0]  sel;
		logic [13:0] yr;
		logic [3:0]  mon;
		logic [4:0]  dom;
		logic [4:0]  hr;
		logic [5:0]  mins;
		logic [5:0]  secs;
	} beat_t;

	// One shifted time stamp.
	typedef struct {
		logic [13:0] yr;
		logic [3:0]  mon;
		logic [4:0]  dom;
		logic [4:0]  hr;
		logic [5:0]  mins;
		logic [5:0]  secs;
		logic [2:0]  wday;
	} stamp_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic signed [16:0] cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         func = '0;
	logic [13:0]        year = '0;
	logic [3:0]         month = '0;
	logic [4:0]         day = '0;
	logic [4:0]         hour = '0;
	logic [5:0]         minute = '0;
	logic [5:0]         second = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [13:0]        out_year;
	logic [3:0]         out_month;
	logic [4:0]         out_day;
	logic [4:0]         out_hour;
	logic [5:0]         out_minute;
	logic [5:0]         out_second;
	logic [2:0]         weekday;

	stamp_t shifted_q[$];
	int     zone_offset = 0;
	int     mismatch_count = 0;
	int     idle_pct = 0;
	int     stall_pct = 0;

	datetime_timezone_shift DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.year       (year),
		.month      (month),
		.day        (day),
		.hour       (hour),
		.minute     (minute),
		.second     (second),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_year   (out_year),
		.out_month  (out_month),
		.out_day    (out_day),
		.out_hour   (out_hour),
		.out_minute (out_minute),
		.out_second (out_second),
		.weekday    (weekday)
	);

	// Clock generation.
	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Gregorian leap-year rule.
	function automatic bit is_leap_year(input int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// Days in a month; months outside 1 to 12 count as 31 days.
	function automatic int month_length(input int y, input int m);
		int lengths[12];
		lengths = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (m < 1 || m > 12) begin
			return 31;
		end
		if (m == 2 && is_leap_year(y)) begin
			return 29;
		end
		return lengths[m - 1];
	endfunction

	// Day of week, 0 is Sunday, with the year biased so every term stays positive.
	function automatic int weekday_of(input int y, input int m, input int d);
		int yy;
		int mm;
		yy = y + WEEK_YEAR_BIAS;
		mm = m;
		if (mm < 3) begin
			yy = yy - 1;
			mm = mm + 12;
		end
		return (yy + yy / 4 - yy / 100 + yy / 400 + (13 * mm + 8) / 5 + d) % 7;
	endfunction

	// Expected result of one beat under the given zone offset.
	function automatic stamp_t shift_stamp(input beat_t b, input int zone);
		stamp_t r;
		int y;
		int m;
		int d;
		int h;
		int mi;
		int s;
		int t;
		r = '{default: '0};
		if (b.sel == FUNC_NONE) begin
			return r;
		end
		y = int'(b.yr);
		m = int'(b.mon);
		d = int'(b.dom);
		h = 0;
		mi = 0;
		s = 0;
		if (b.sel != FUNC_DATE) begin
			h = int'(b.hr);
			mi = int'(b.mins);
			s = int'(b.secs);
			if (zone != 0) begin
				t = h * HOUR_SECS + mi * 60 + s + zone;
				if (t < 0) begin
					// Step back one day.
					if (d <= 1) begin
						if (m <= 1) begin
							if (y > EARLY_YEAR) begin
								y = y - 1;
							end
							m = 12;
						end else begin
							m = m - 1;
						end
						d = month_length(y, m);
					end else begin
						d = d - 1;
					end
					t = t + DAY_SECS;
				end else if (t >= DAY_SECS) begin
					// Step forward one day; the year wraps at 14 bits.
					if (d >= month_length(y, m)) begin
						if (m >= 12) begin
							y = (y + 1) % 16384;
							m = 1;
						end else begin
							m = m + 1;
						end
						d = 1;
					end else begin
						d = d + 1;
					end
					t = t - DAY_SECS;
				end
				if (t < 0) begin
					t = 0;
				end
				if (t > DAY_SECS - 1) begin
					t = DAY_SECS - 1;
				end
				h = t / HOUR_SECS;
				mi = (t % HOUR_SECS) / 60;
				s = (t % HOUR_SECS) % 60;
			end
		end
		r.yr = 14'(y);
		r.mon = 4'(m);
		r.dom = 5'(d);
		r.hr = 5'(h);
		r.mins = 6'(mi);
		r.secs = 6'(s);
		r.wday = 3'(weekday_of(y, m, d));
		return r;
	endfunction

	function automatic beat_t make_beat(input logic [1:0] sel, input int y, input int m,
			input int d, input int h, input int mi, input int s);
		beat_t b;
		b.sel = sel;
		b.yr = 14'(y);
		b.mon = 4'(m);
		b.dom = 5'(d);
		b.hr = 5'(h);
		b.mins = 6'(mi);
		b.secs = 6'(s);
		return b;
	endfunction

	// Random beat: mostly well-formed dates near the interesting boundaries,
	// with a share of raw field values.
	function automatic beat_t random_beat();
		beat_t b;
		int pick;
		int y;
		int m;
		int d;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			b.sel = FUNC_NONE;
		end else if (pick < 25) begin
			b.sel = FUNC_DATE;
		end else if (pick < 90) begin
			b.sel = FUNC_DATETIME;
		end else begin
			b.sel = FUNC_ALIAS;
		end
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			y = $urandom_range(1, 9999);
		end else if (pick < 75) begin
			y = $urandom_range(1899, 1903);
		end else if (pick < 80) begin
			y = $urandom_range(9998, 9999);
		end else if (pick < 85) begin
			y = $urandom_range(16382, 16383);
		end else begin
			y = $urandom_range(0, 16383);
		end
		m = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 12) : $urandom_range(0, 15);
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			d = $urandom_range(1, month_length(y, m));
		end else if (pick < 65) begin
			d = 1;
		end else if (pick < 90) begin
			d = month_length(y, m);
		end else begin
			d = $urandom_range(0, 31);
		end
		b.yr = 14'(y);
		b.mon = 4'(m);
		b.dom = 5'(d);
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			b.hr = 5'($urandom_range(0, 1));
		end else if (pick < 70) begin
			b.hr = 5'($urandom_range(22, 23));
		end else if (pick < 90) begin
			b.hr = 5'($urandom_range(0, 23));
		end else begin
			b.hr = 5'($urandom_range(0, 31));
		end
		b.mins = 6'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 59) : $urandom_range(0, 63));
		b.secs = 6'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 59) : $urandom_range(0, 63));
		return b;
	endfunction

	// Random zone offset, weighted toward zero and the extremes.
	function automatic int random_zone();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: return 0;
			1: return ZONE_MAX;
			2: return ZONE_MIN;
			3: return ZONE_SPAN;
			4: return -ZONE_SPAN;
			5, 6: return int'($urandom_range(0, 2 * ZONE_SPAN)) - ZONE_SPAN;
			7: return int'($urandom_range(0, 2 * HOUR_SECS)) - HOUR_SECS;
			default: return int'($urandom_range(0, 131071)) + ZONE_MIN;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_stamp(input stamp_t got, input stamp_t want);
		if (got.yr !== want.yr) report_mismatch("out_year", int'(got.yr), int'(want.yr));
		if (got.mon !== want.mon) report_mismatch("out_month", int'(got.mon), int'(want.mon));
		if (got.dom !== want.dom) report_mismatch("out_day", int'(got.dom), int'(want.dom));
		if (got.hr !== want.hr) report_mismatch("out_hour", int'(got.hr), int'(want.hr));
		if (got.mins !== want.mins)
			report_mismatch("out_minute", int'(got.mins), int'(want.mins));
		if (got.secs !== want.secs)
			report_mismatch("out_second", int'(got.secs), int'(want.secs));
		if (got.wday !== want.wday) report_mismatch("weekday", int'(got.wday), int'(want.wday));
	endtask

	// Receiver side: random stall per cycle.
	always @(posedge clk) begin
		out_stall <= arst_n && ($urandom_range(0, 99) < stall_pct);
	end

	// Every accepted result beat is compared with the oldest expected stamp.
	always @(posedge clk) begin
		stamp_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{out_year, out_month, out_day, out_hour, out_minute, out_second, weekday};
			if (shifted_q.size() == 0) begin
				report_mismatch("unexpected result beat, out_year", int'(got.yr), 0);
			end else begin
				check_stamp(got, shifted_q.pop_front());
			end
		end
	end

	// Sends one beat after an optional random gap and records its expected stamp.
	task automatic send_beat(input beat_t b);
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
		in_valid <= 1'b1;
		func <= b.sel;
		year <= b.yr;
		month <= b.mon;
		day <= b.dom;
		hour <= b.hr;
		minute <= b.mins;
		second <= b.secs;
		do @(posedge clk); while (in_stall);
		shifted_q.insert(shifted_q.size(), shift_stamp(b, zone_offset));
	endtask

	// Waits until every expected beat is out and the pipeline has emptied.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (shifted_q.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task automatic set_zone_offset(input int z);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= 17'(z);
		@(posedge clk);
		cfg_we <= 1'b0;
		zone_offset = z;
	endtask

	// Selector codes, the zero offset pass-through, and selectors under a nonzero offset.
	task automatic test_selectors();
		set_zone_offset(0);
		send_beat(make_beat(FUNC_NONE, 16383, 15, 31, 31, 63, 63));
		send_beat(make_beat(FUNC_DATE, 2024, 2, 29, 31, 63, 63));
		send_beat(make_beat(FUNC_DATETIME, 1, 1, 1, 0, 0, 0));
		send_beat(make_beat(FUNC_ALIAS, 9999, 12, 31, 23, 59, 59));
		send_beat(make_beat(FUNC_DATETIME, 0, 0, 0, 31, 63, 63));
		set_zone_offset(ZONE_SPAN);
		send_beat(make_beat(FUNC_DATE, 2000, 12, 31, 23, 59, 59));
		send_beat(make_beat(FUNC_ALIAS, 2000, 12, 31, 23, 0, 0));
	endtask

	// Midnight crossings backward and forward, with leap years and early years.
	task automatic test_day_rollover();
		set_zone_offset(-HOUR_SECS);
		send_beat(make_beat(FUNC_DATETIME, 2000, 3, 1, 0, 30, 0));
		send_beat(make_beat(FUNC_DATETIME, 1900, 3, 1, 0, 0, 0));
		send_beat(make_beat(FUNC_DATETIME, 1901, 1, 1, 0, 0, 0));
		send_beat(make_beat(FUNC_DATETIME, 1902, 1, 1, 0, 59, 59));
		set_zone_offset(HOUR_SECS);
		send_beat(make_beat(FUNC_DATETIME, 9999, 12, 31, 23, 30, 0));
		send_beat(make_beat(FUNC_DATETIME, 16383, 12, 31, 23, 0, 0));
		send_beat(make_beat(FUNC_DATETIME, 2024, 2, 29, 23, 0, 0));
		send_beat(make_beat(FUNC_DATETIME, 2023, 2, 28, 23, 0, 0));
	endtask

	// Months and days outside their ranges.
	task automatic test_malformed_fields();
		set_zone_offset(-HOUR_SECS);
		send_beat(make_beat(FUNC_DATETIME, 2010, 0, 1, 0, 0, 0));
		send_beat(make_beat(FUNC_DATETIME, 2010, 13, 1, 0, 0, 0));
		send_beat(make_beat(FUNC_DATETIME, 2010, 5, 0, 0, 0, 0));
		set_zone_offset(HOUR_SECS);
		send_beat(make_beat(FUNC_DATETIME, 2010, 14, 31, 23, 0, 0));
		send_beat(make_beat(FUNC_DATETIME, 2010, 4, 31, 23, 0, 0));
	endtask

	// Offsets at the limits of the register, with oversized time fields.
	task automatic test_offset_extremes();
		set_zone_offset(ZONE_MAX);
		send_beat(make_beat(FUNC_DATETIME, 1999, 12, 31, 31, 63, 63));
		set_zone_offset(ZONE_MIN);
		send_beat(make_beat(FUNC_DATETIME, 2001, 1, 1, 0, 0, 0));
		set_zone_offset(-ZONE_SPAN);
		send_beat(make_beat(FUNC_DATETIME, 2004, 3, 1, 13, 59, 59));
	endtask

	// Random beats in chunks, each chunk under a fresh zone offset.
	task automatic test_random_phase(input int count, input int gap_pct, input int hold_pct);
		idle_pct = gap_pct;
		stall_pct = hold_pct;
		for (int n = 0; n < count; n++) begin
			if (n % 85 == 0) begin
				set_zone_offset(random_zone());
			end
			send_beat(random_beat());
		end
	endtask

	// Run limit.
	initial begin
		#10_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// Test sequence.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_selectors();
		test_day_rollover();
		test_malformed_fields();
		test_offset_extremes();
		test_random_phase(425, 0, 0);
		test_random_phase(425, 75, 0);
		test_random_phase(425, 0, 75);
		test_random_phase(425, 30, 30);
		wait_idle();
		repeat (PIPE_DEPTH * 2) @(posedge clk);
		if (shifted_q.size() != 0) begin
			report_mismatch("results still expected", 0, shifted_q.size());
		end
		if (mismatch_count == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
